// ===== design/amfi_pkg.sv =====
package amfi_pkg;

  // register and field widths
  localparam int TIME_STEP_W = 16;
  localparam int GRAVITY_W   = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // register reset values: dt of 655/65536 s, g of 2511/256 m/s^2
  localparam int TIME_STEP_RST = 655;
  localparam int GRAVITY_RST   = 2511;

  // accumulator and result widths
  localparam int VEL_W = 40;
  localparam int POS_W = 48;
  localparam int OUT_W = 32;
  localparam int AXES  = 3;

  // velocity carries 24 fraction bits, results 16; disp and mean each drop 8
  localparam int DISP_SHIFT = 8;
  localparam int MEAN_SHIFT = 8;
  localparam int DIV_ITERS  = VEL_W - MEAN_SHIFT;

  // parameter defaults
  localparam int MAX_SAMPLES_DEF  = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_GRAVITY   = 2'd1
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic upd;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

// ===== design/amfi_intf.sv =====
interface amfi_in_if #(
  parameter int SAMPLE_WIDTH = amfi_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic                           last_sample;

  modport source (output valid, accel_x, accel_y, accel_z, last_sample, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, last_sample, output ready);
endinterface

interface amfi_out_if #(
  parameter int COUNT_W = $clog2(amfi_pkg::MAX_SAMPLES_DEF + 1)
);
  logic                             valid;
  logic                             ready;
  logic signed [amfi_pkg::OUT_W-1:0] disp_x;
  logic signed [amfi_pkg::OUT_W-1:0] disp_y;
  logic signed [amfi_pkg::OUT_W-1:0] disp_z;
  logic signed [amfi_pkg::OUT_W-1:0] mean_vel_x;
  logic signed [amfi_pkg::OUT_W-1:0] mean_vel_y;
  logic signed [amfi_pkg::OUT_W-1:0] mean_vel_z;
  logic [COUNT_W-1:0]               sample_count;
  logic                             saturated;

  modport source (output valid, disp_x, disp_y, disp_z, mean_vel_x, mean_vel_y, mean_vel_z,
                  sample_count, saturated, input ready);
  modport sink   (input valid, disp_x, disp_y, disp_z, mean_vel_x, mean_vel_y, mean_vel_z,
                  sample_count, saturated, output ready);
endinterface

interface amfi_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [amfi_pkg::CFG_IDX_W-1:0]  index;
  logic [amfi_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/amfi_ctrl.sv =====
module amfi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  amfi_pkg::stat_t stat_i,
  output amfi_pkg::cmd_t  cmd_o
);

  localparam int CNT_W = $clog2(amfi_pkg::DIV_ITERS);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL1  = 8'b0000_0010,
    ST_MUL2  = 8'b0000_0100,
    ST_SUM   = 8'b0000_1000,
    ST_UPD   = 8'b0001_0000,
    ST_DINIT = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  logic               out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.sum      = (state_q == ST_SUM);
    cmd_o.upd      = (state_q == ST_UPD);
    cmd_o.div_init = (state_q == ST_DINIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.emit     = (state_q == ST_EMIT) && out_free;
  end

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MUL1;
      end
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_UPD;
      ST_UPD: begin
        state_d = stat_i.last ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        state_d   = ST_DIV;
        div_cnt_d = CNT_W'(amfi_pkg::DIV_ITERS - 1);
      end
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          div_cnt_d = div_cnt_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/amfi_datapath.sv =====
module amfi_datapath #(
  parameter  int MAX_SAMPLES  = amfi_pkg::MAX_SAMPLES_DEF,
  parameter  int SAMPLE_WIDTH = amfi_pkg::SAMPLE_WIDTH_DEF,
  localparam int CNT_W        = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [amfi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [amfi_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      accel_z_i,
  input  logic                                last_sample_i,
  input  amfi_pkg::cmd_t                      cmd_i,
  output amfi_pkg::stat_t                     stat_o,
  output logic signed [amfi_pkg::OUT_W-1:0]   disp_o [amfi_pkg::AXES],
  output logic signed [amfi_pkg::OUT_W-1:0]   mean_vel_o [amfi_pkg::AXES],
  output logic [CNT_W-1:0]                    sample_count_o,
  output logic                                saturated_o
);

  localparam int AXES   = amfi_pkg::AXES;
  localparam int VEL_W  = amfi_pkg::VEL_W;
  localparam int POS_W  = amfi_pkg::POS_W;
  localparam int OUT_W  = amfi_pkg::OUT_W;
  localparam int DT_W   = amfi_pkg::TIME_STEP_W;
  localparam int GR_W   = amfi_pkg::GRAVITY_W;
  localparam int Q_W    = amfi_pkg::DIV_ITERS;

  localparam int A_W    = SAMPLE_WIDTH + 1;          // z after gravity removal
  localparam int T_W    = DT_W + 1;                  // dt as signed operand
  localparam int G_W    = GR_W + 1;
  localparam int AG_W   = A_W + G_W;                 // a*g
  localparam int ADG_W  = AG_W + T_W;                // a*dt*g, 36 fraction bits
  localparam int DD_W   = 2 * DT_W;                  // dt*dt
  localparam int D2_W   = AG_W + DD_W + 1;           // a*g*dt*dt, 52 fraction bits
  localparam int HALF_SHIFT = 13;                    // to 40 fraction bits and halved
  localparam int T2_W   = D2_W - HALF_SHIFT;
  localparam int VL_W   = 20;                        // velocity split for v*dt
  localparam int VH_W   = VEL_W - VL_W;
  localparam int VHP_W  = VH_W + T_W;
  localparam int VLP_W  = VL_W + DT_W;
  localparam int T1_W   = VEL_W + T_W;               // v*dt, 40 fraction bits
  localparam int S_W    = ((T1_W > T2_W) ? T1_W : T2_W) + 1;
  localparam int DP_SHIFT = 16;
  localparam int DP_W   = S_W - DP_SHIFT;
  localparam int VR_SHIFT = 12;
  localparam int VINC_W = ADG_W + 1 - VR_SHIFT;
  localparam int VSUM_W = ((VEL_W > VINC_W) ? VEL_W : VINC_W) + 1;
  localparam int PSUM_W = ((POS_W > DP_W) ? POS_W : DP_W) + 1;
  localparam int DR_W   = POS_W + 1 - amfi_pkg::DISP_SHIFT;

  localparam logic signed [A_W-1:0]   ONE_G   = A_W'(1 << (SAMPLE_WIDTH - 4));
  localparam logic signed [S_W-1:0]   DP_RND  = S_W'(1 << (DP_SHIFT - 1));
  localparam logic signed [ADG_W:0]   VR_RND  = (ADG_W + 1)'(1 << (VR_SHIFT - 1));
  localparam logic signed [POS_W:0]   D_RND   = (POS_W + 1)'(1 << (amfi_pkg::DISP_SHIFT - 1));

  // configuration registers
  logic [DT_W-1:0] time_step_q;
  logic [GR_W-1:0] gravity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= DT_W'(amfi_pkg::TIME_STEP_RST);
      gravity_q   <= GR_W'(amfi_pkg::GRAVITY_RST);
    end else if (cfg_valid_i) begin
      case (amfi_pkg::cfg_reg_e'(cfg_index_i))
        amfi_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i[DT_W-1:0];
        amfi_pkg::CFG_GRAVITY:   gravity_q   <= cfg_data_i[GR_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [T_W-1:0]  dt_s;
  logic signed [G_W-1:0]  g_s;
  logic [DD_W-1:0]        dd_q;
  logic signed [DD_W:0]   dd_s;

  assign dt_s = $signed({1'b0, time_step_q});
  assign g_s  = $signed({1'b0, gravity_q});
  assign dd_s = $signed({1'b0, dd_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) dd_q <= DD_W'(time_step_q) * DD_W'(time_step_q);
  end

  // shared gesture state
  logic [CNT_W-1:0] cnt_q;
  logic             ovf_q;
  logic             last_q;
  logic             cnt_full;
  logic [AXES-1:0]  vel_ovf, pos_ovf, disp_ovf, mean_ovf;
  logic signed [SAMPLE_WIDTH-1:0] accel_in [AXES];

  assign accel_in[0] = accel_x_i;
  assign accel_in[1] = accel_y_i;
  assign accel_in[2] = accel_z_i;
  assign cnt_full    = (cnt_q >= CNT_W'(MAX_SAMPLES));
  assign stat_o.last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.load) last_q <= last_sample_i;
      if (cmd_i.emit) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.upd) begin
        if (!cnt_full) cnt_q <= cnt_q + 1'b1;
        ovf_q <= ovf_q | (|vel_ovf) | (|pos_ovf) | cnt_full;
      end
    end
  end

  logic [CNT_W-1:0] count_out_q;
  logic             sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      count_out_q <= cnt_q;
      sat_q       <= ovf_q | (|disp_ovf) | (|mean_ovf);
    end
  end

  assign sample_count_o = count_out_q;
  assign saturated_o    = sat_q;

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    logic signed [A_W-1:0]    a_ext, a_q;
    logic signed [AG_W-1:0]   ag_q;
    logic signed [VHP_W-1:0]  vhp_q;
    logic [VLP_W-1:0]         vlp_q;
    logic signed [ADG_W-1:0]  adg_q;
    logic signed [D2_W-1:0]   add2_q;
    logic signed [T1_W-1:0]   t1_q;
    logic signed [T2_W-1:0]   t2;
    logic signed [S_W-1:0]    s_sum;
    logic signed [DP_W-1:0]   dp_q;
    logic signed [ADG_W:0]    v_rnd;
    logic signed [VINC_W-1:0] vinc_q;
    logic signed [VSUM_W-1:0] v_sum;
    logic signed [PSUM_W-1:0] p_sum;
    logic signed [VEL_W-1:0]  vel_q;
    logic signed [POS_W-1:0]  pos_q;
    logic [VEL_W-1:0]         mag, numer;
    logic [CNT_W-1:0]         rem_q;
    logic [Q_W-1:0]           dq_q;
    logic [CNT_W:0]           trial;
    logic                     fits;
    logic signed [POS_W:0]    p_rnd;
    logic signed [DR_W-1:0]   d_rnd;
    logic signed [Q_W:0]      m_val;
    logic signed [OUT_W-1:0]  disp_q, mean_q;

    // only z carries gravity
    if (i == AXES - 1) begin : g_grav
      assign a_ext = A_W'(accel_in[i]) - ONE_G;
    end else begin : g_plain
      assign a_ext = A_W'(accel_in[i]);
    end

    assign t2    = $signed(add2_q[D2_W-1:HALF_SHIFT]);
    assign s_sum = S_W'(t1_q) + S_W'(t2) + DP_RND;
    assign v_rnd = (ADG_W + 1)'(adg_q) + VR_RND;
    assign v_sum = VSUM_W'(vel_q) + VSUM_W'(vinc_q);
    assign p_sum = PSUM_W'(pos_q) + PSUM_W'(dp_q);

    assign vel_ovf[i] = (|v_sum[VSUM_W-1:VEL_W-1]) && !(&v_sum[VSUM_W-1:VEL_W-1]);
    assign pos_ovf[i] = (|p_sum[PSUM_W-1:POS_W-1]) && !(&p_sum[PSUM_W-1:POS_W-1]);

    // mean = round(|v| / (256*n)), taken as ((|v| + 128*n) >> 8) / n
    assign mag   = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);
    assign numer = mag + (VEL_W'(cnt_q) << (amfi_pkg::MEAN_SHIFT - 1));
    assign trial = {rem_q, dq_q[Q_W-1]};
    assign fits  = (trial >= {1'b0, cnt_q});

    assign p_rnd = (POS_W + 1)'(pos_q) + D_RND;
    assign d_rnd = $signed(p_rnd[POS_W:amfi_pkg::DISP_SHIFT]);
    assign m_val = vel_q[VEL_W-1] ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

    assign disp_ovf[i] = (|d_rnd[DR_W-1:OUT_W-1]) && !(&d_rnd[DR_W-1:OUT_W-1]);
    assign mean_ovf[i] = (|m_val[Q_W:OUT_W-1]) && !(&m_val[Q_W:OUT_W-1]);

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) a_q <= a_ext;
      if (cmd_i.mul1) begin
        ag_q  <= AG_W'(a_q) * AG_W'(g_s);
        vhp_q <= VHP_W'($signed(vel_q[VEL_W-1:VL_W])) * VHP_W'(dt_s);
        vlp_q <= VLP_W'(vel_q[VL_W-1:0]) * VLP_W'(time_step_q);
      end
      if (cmd_i.mul2) begin
        adg_q  <= ADG_W'(ag_q) * ADG_W'(dt_s);
        add2_q <= D2_W'(ag_q) * D2_W'(dd_s);
        t1_q   <= (T1_W'(vhp_q) <<< VL_W) + T1_W'($signed({1'b0, vlp_q}));
      end
      if (cmd_i.sum) begin
        dp_q   <= $signed(s_sum[S_W-1:DP_SHIFT]);
        vinc_q <= $signed(v_rnd[ADG_W:VR_SHIFT]);
      end
      if (cmd_i.div_init) begin
        rem_q <= '0;
        dq_q  <= numer[VEL_W-1:amfi_pkg::MEAN_SHIFT];
      end else if (cmd_i.div_step) begin
        rem_q <= fits ? CNT_W'(trial - {1'b0, cnt_q}) : trial[CNT_W-1:0];
        dq_q  <= {dq_q[Q_W-2:0], fits};
      end
      if (cmd_i.emit) begin
        disp_q <= disp_ovf[i] ? {d_rnd[DR_W-1], {(OUT_W-1){~d_rnd[DR_W-1]}}}
                              : d_rnd[OUT_W-1:0];
        mean_q <= mean_ovf[i] ? {m_val[Q_W], {(OUT_W-1){~m_val[Q_W]}}}
                              : m_val[OUT_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vel_q <= '0;
        pos_q <= '0;
      end else if (cmd_i.emit) begin
        vel_q <= '0;
        pos_q <= '0;
      end else if (cmd_i.upd) begin
        vel_q <= vel_ovf[i] ? {v_sum[VSUM_W-1], {(VEL_W-1){~v_sum[VSUM_W-1]}}}
                            : v_sum[VEL_W-1:0];
        pos_q <= pos_ovf[i] ? {p_sum[PSUM_W-1], {(POS_W-1){~p_sum[PSUM_W-1]}}}
                            : p_sum[POS_W-1:0];
      end
    end

    assign disp_o[i]     = disp_q;
    assign mean_vel_o[i] = mean_q;
  end

endmodule

// ===== design/accel_motion_feature_integrator_top.sv =====
// each sample request runs accept, then two multiply steps, sum and update, before the next accept
// a last-sample request then adds a divider init step and the 32-step restoring divider that
//   forms the three mean velocities in parallel; the result is loaded into the output register
//   in the emit state, which waits until the previous result has been taken
// reset: accumulators, count and flags clear at once, time_step 655, gravity_scale 2511
module accel_motion_feature_integrator_top #(
  parameter int MAX_SAMPLES  = amfi_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = amfi_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  amfi_in_if.sink   sample_i,
  amfi_out_if.source result_o,
  amfi_cfg_if.sink  cfg_i
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  // command and status between sequencer and datapath
  amfi_pkg::cmd_t  cmd;
  amfi_pkg::stat_t stat;

  logic signed [amfi_pkg::OUT_W-1:0] disp     [amfi_pkg::AXES];
  logic signed [amfi_pkg::OUT_W-1:0] mean_vel [amfi_pkg::AXES];
  logic [CNT_W-1:0]                  sample_count;
  logic                              saturated;

  // register writes are always accepted and never stalled
  assign cfg_i.ready = 1'b1;

  // sequencer: one sample in flight, output register frees the input side
  amfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // three axis lanes: integrate, then round, divide and saturate on the last sample
  amfi_datapath #(
    .MAX_SAMPLES  (MAX_SAMPLES),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_i.valid && cfg_i.ready),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .accel_x_i      (sample_i.accel_x),
    .accel_y_i      (sample_i.accel_y),
    .accel_z_i      (sample_i.accel_z),
    .last_sample_i  (sample_i.last_sample),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .disp_o         (disp),
    .mean_vel_o     (mean_vel),
    .sample_count_o (sample_count),
    .saturated_o    (saturated)
  );

  // result payload straight from the datapath output registers
  assign result_o.disp_x       = disp[0];
  assign result_o.disp_y       = disp[1];
  assign result_o.disp_z       = disp[2];
  assign result_o.mean_vel_x   = mean_vel[0];
  assign result_o.mean_vel_y   = mean_vel[1];
  assign result_o.mean_vel_z   = mean_vel[2];
  assign result_o.sample_count = sample_count;
  assign result_o.saturated    = saturated;

  // output register is only reloaded once its previous result has gone
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!result_o.valid || result_o.ready))
    else $error("result reloaded while still pending");

  // an accepted sample keeps the sequencer busy for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("second sample accepted while one is in flight");

  // a result always covers at least one sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.sample_count != '0))
    else $error("result with zero sample count");

endmodule
